/* sv/char_code_to_glyph_index_core_defines.svh */
// ----------------------------------------------------------------------------
// Glyph index lookup assertion macros
// Shorthand for clocked assertions on the lookup core's ports.
// ----------------------------------------------------------------------------
`ifndef CHAR_CODE_TO_GLYPH_INDEX_CORE_DEFINES_SVH
`define CHAR_CODE_TO_GLYPH_INDEX_CORE_DEFINES_SVH

// Consequence holds in the same cycle as the condition.
`define CCG_ASSERT_NOW(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (cons)) \
      else $error(msg);

// Consequence holds in the cycle after the condition.
`define CCG_ASSERT_NEXT(label, cond, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (cons)) \
      else $error(msg);

`endif

/* sv/ccg_pkg.sv */
// ----------------------------------------------------------------------------
// Glyph index lookup package
// Shared widths, codes and types of the character code to glyph index core.
// ----------------------------------------------------------------------------
`default_nettype none

package ccg_pkg;

   localparam int CODE_W = 16;
   localparam int WORD_W = 16;
   localparam int BASE_W = 12;
   // full word address before wrap: base + 1 + 2 * probe, below 2^18
   localparam int FA_W   = 18;

   localparam int DEF_RANGE_SLOTS      = 8;
   localparam int DEF_WORD_STORE_DEPTH = 4096;

   localparam logic [CODE_W-1:0] NOT_FOUND_INDEX = 16'hFFFF;

   typedef enum logic [1:0] {
      ACT_LOOKUP     = 2'd0,
      ACT_LOAD_RANGE = 2'd1,
      ACT_LOAD_WORD  = 2'd2,
      ACT_NONE       = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      METH_DIRECT = 2'd0,
      METH_TABLE  = 2'd1,
      METH_SCAN   = 2'd2,
      METH_NONE   = 2'd3
   } method_type;

   // what the pending word fetch is for
   typedef enum logic [2:0] {
      PURP_DIRECT = 3'd0,
      PURP_TABLE  = 3'd1,
      PURP_COUNT  = 3'd2,
      PURP_KEY    = 3'd3,
      PURP_VALUE  = 3'd4,
      PURP_WRITE  = 3'd5
   } purp_type;

   typedef enum logic [6:0] {
      ST_IDLE   = 7'b0000001,
      ST_SLOT   = 7'b0000010,
      ST_SEARCH = 7'b0000100,
      ST_MOD    = 7'b0001000,
      ST_ACCESS = 7'b0010000,
      ST_DATA   = 7'b0100000,
      ST_DONE   = 7'b1000000
   } state_type;

   typedef struct packed {
      logic [CODE_W-1:0] code_begin;
      logic [CODE_W-1:0] code_end;
      logic [1:0]        map_method;
      logic [BASE_W-1:0] info_base;
   } desc_type;

endpackage

`default_nettype wire

/* sv/char_code_to_glyph_index_core.sv */
// ----------------------------------------------------------------------------
// Character code to glyph index core
// Range descriptor search with direct, table and binary-scan word maps.
// ----------------------------------------------------------------------------
// One sequencer walks every transaction through a single descriptor compare,
// one single-port word store and one modular-wrap subtractor, so the block
// takes one transaction at a time and holds req_stall high while busy.
// Work per transaction, with R the wrap steps of one word fetch: R = 0 for a
// power-of-two WORD_STORE_DEPTH and R = 19 - clog2(WORD_STORE_DEPTH)
// otherwise (the wrap subtractor takes one step a cycle):
//   cache hit, descriptor load, unused action: no word fetch;
//   word load: R wrap steps and one write;
//   lookup: S slot checks and F word fetches, where S is the number of slots
//   checked (one per cycle, up to RANGE_SLOTS), F the number of word fetches
//   (one for direct and table, up to 1 + P + 1 for scan) and P the binary
//   search probes (about log2 of the pair count).
// The word store has no clearing pass: an entry must be written before any
// lookup reads it.
// The result sits in an output register, so a new transaction is taken while
// the previous result still waits for rsp_stall to drop.
// ----------------------------------------------------------------------------
`default_nettype none

module char_code_to_glyph_index_core #(
   parameter int RANGE_SLOTS      = ccg_pkg::DEF_RANGE_SLOTS,
   parameter int WORD_STORE_DEPTH = ccg_pkg::DEF_WORD_STORE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // alternate index register
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [15:0] csr_data,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_action,
   input  wire logic [15:0] req_char_code,
   input  wire logic [2:0]  req_map_slot,
   input  wire logic        req_slot_enable,
   input  wire logic [15:0] req_code_begin,
   input  wire logic [15:0] req_code_end,
   input  wire logic [1:0]  req_map_method,
   input  wire logic [11:0] req_info_base,
   input  wire logic [11:0] req_word_address,
   input  wire logic [15:0] req_word_value,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [15:0]      rsp_glyph_index,
   output logic             rsp_found,
   output logic             rsp_cache_hit
);

   localparam int FA_W      = ccg_pkg::FA_W;
   localparam int SLOT_W    = (RANGE_SLOTS > 1) ? $clog2(RANGE_SLOTS) : 1;
   localparam int ADDR_W    = $clog2(WORD_STORE_DEPTH);
   localparam bit IS_POW2   = (WORD_STORE_DEPTH & (WORD_STORE_DEPTH - 1)) == 0;
   // restoring-subtract steps to wrap an FA_W-bit address into the store
   localparam int RED_STEPS = IS_POW2 ? 0 : FA_W + 1 - ADDR_W;
   localparam int RC_W      = $clog2(FA_W + 1);
   localparam logic [RC_W-1:0]   RED_TOP   = RC_W'((RED_STEPS > 0) ? RED_STEPS - 1 : 0);
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RANGE_SLOTS - 1);
   localparam ccg_pkg::state_type FETCH_STATE =
      (RED_STEPS > 0) ? ccg_pkg::ST_MOD : ccg_pkg::ST_ACCESS;

   // sequencer and working registers
   ccg_pkg::state_type state_ff, state_in;
   ccg_pkg::purp_type  purp_ff, purp_in;
   logic [SLOT_W-1:0]  slot_cnt_ff, slot_cnt_in;
   logic [RC_W-1:0]    red_cnt_ff, red_cnt_in;
   logic [FA_W-1:0]    fa_ff, fa_in;
   logic [15:0]        code_ff, code_in;
   logic [15:0]        off_ff, off_in;
   logic [11:0]        base_ff, base_in;
   logic [15:0]        wval_ff, wval_in;
   logic [16:0]        mid_ff, mid_in;
   logic signed [17:0] lo_ff, lo_in;
   logic signed [17:0] hi_ff, hi_in;

   // pending result
   logic [15:0]        res_idx_ff, res_idx_in;
   logic               res_lookup_ff, res_lookup_in;
   logic               res_hit_ff, res_hit_in;

   // architectural state
   logic [RANGE_SLOTS-1:0] en_ff, en_in;
   logic [15:0]        cached_code_ff, cached_code_in;
   logic [15:0]        cached_index_ff, cached_index_in;
   logic [15:0]        alt_ff, alt_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic [15:0]        rsp_glyph_ff, rsp_glyph_in;
   logic               rsp_found_ff, rsp_found_in;
   logic               rsp_hit_ff, rsp_hit_in;

   // stores
   ccg_pkg::desc_type  desc_mem [RANGE_SLOTS];
   ccg_pkg::desc_type  desc_rd_ff;
   ccg_pkg::desc_type  desc_wdata;
   logic               desc_we;
   logic [SLOT_W-1:0]  desc_waddr;
   logic [15:0]        word_mem [WORD_STORE_DEPTH];
   logic [15:0]        word_rd_ff;
   logic               mem_we;

   logic               accept;
   logic               slot_ok;
   logic               range_hit;
   logic [FA_W:0]      red_sub;
   logic signed [17:0] probe_sum;
   logic [16:0]        probe_mid;

   assign csr_ready = 1'b1;
   assign req_stall = state_ff != ccg_pkg::ST_IDLE;
   assign accept    = req_valid && !req_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_glyph_index = rsp_glyph_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_cache_hit   = rsp_hit_ff;

   // descriptor writes go straight in at accept; slots past the table drop
   assign slot_ok    = 7'(req_map_slot) < 7'(RANGE_SLOTS);
   assign desc_waddr = SLOT_W'(req_map_slot);
   assign desc_we    = accept && (req_action == ccg_pkg::ACT_LOAD_RANGE) && slot_ok;
   assign desc_wdata = '{code_begin: req_code_begin, code_end: req_code_end,
                         map_method: req_map_method, info_base: req_info_base};

   // desc_rd_ff always holds the descriptor of slot_cnt_ff
   assign range_hit = en_ff[slot_cnt_ff] &&
                      (code_ff >= desc_rd_ff.code_begin) &&
                      (code_ff <= desc_rd_ff.code_end);

   // wrap subtractor operand: store depth shifted to the current step
   assign red_sub   = (FA_W + 1)'(WORD_STORE_DEPTH) << red_cnt_ff;

   // probe midpoint; lo and hi are both non-negative whenever a probe runs
   assign probe_sum = lo_ff + hi_ff;
   assign probe_mid = probe_sum[17:1];

   always_comb begin
      state_in        = state_ff;
      purp_in         = purp_ff;
      slot_cnt_in     = slot_cnt_ff;
      red_cnt_in      = red_cnt_ff;
      fa_in           = fa_ff;
      code_in         = code_ff;
      off_in          = off_ff;
      base_in         = base_ff;
      wval_in         = wval_ff;
      mid_in          = mid_ff;
      lo_in           = lo_ff;
      hi_in           = hi_ff;
      res_idx_in      = res_idx_ff;
      res_lookup_in   = res_lookup_ff;
      res_hit_in      = res_hit_ff;
      en_in           = en_ff;
      cached_code_in  = cached_code_ff;
      cached_index_in = cached_index_ff;
      alt_in          = alt_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_glyph_in    = rsp_glyph_ff;
      rsp_found_in    = rsp_found_ff;
      rsp_hit_in      = rsp_hit_ff;
      mem_we          = 1'b0;

      if (csr_valid && csr_ready) begin
         alt_in = csr_data;
      end

      // drop the result once the far side takes it
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ccg_pkg::ST_IDLE: begin
            if (accept) begin
               res_hit_in    = 1'b0;
               res_lookup_in = 1'b0;
               case (req_action)
                  ccg_pkg::ACT_LOOKUP: begin
                     res_lookup_in = 1'b1;
                     if (req_char_code == cached_code_ff) begin
                        // answer from the last-code cache, even right after reset
                        res_idx_in = cached_index_ff;
                        res_hit_in = 1'b1;
                        state_in   = ccg_pkg::ST_DONE;
                     end else begin
                        cached_code_in = req_char_code;
                        code_in        = req_char_code;
                        slot_cnt_in    = '0;
                        state_in       = ccg_pkg::ST_SLOT;
                     end
                  end
                  ccg_pkg::ACT_LOAD_RANGE: begin
                     if (slot_ok) begin
                        en_in[desc_waddr] = req_slot_enable;
                     end
                     cached_code_in  = '0;
                     cached_index_in = ccg_pkg::NOT_FOUND_INDEX;
                     state_in        = ccg_pkg::ST_DONE;
                  end
                  ccg_pkg::ACT_LOAD_WORD: begin
                     cached_code_in  = '0;
                     cached_index_in = ccg_pkg::NOT_FOUND_INDEX;
                     fa_in           = FA_W'(req_word_address);
                     wval_in         = req_word_value;
                     purp_in         = ccg_pkg::PURP_WRITE;
                     red_cnt_in      = RED_TOP;
                     state_in        = FETCH_STATE;
                  end
                  default: begin
                     state_in = ccg_pkg::ST_DONE;
                  end
               endcase
            end
         end

         ccg_pkg::ST_SLOT: begin
            if (range_hit) begin
               off_in     = code_ff - desc_rd_ff.code_begin;
               base_in    = desc_rd_ff.info_base;
               red_cnt_in = RED_TOP;
               case (desc_rd_ff.map_method)
                  ccg_pkg::METH_DIRECT: begin
                     fa_in    = FA_W'(desc_rd_ff.info_base);
                     purp_in  = ccg_pkg::PURP_DIRECT;
                     state_in = FETCH_STATE;
                  end
                  ccg_pkg::METH_TABLE: begin
                     fa_in    = FA_W'(desc_rd_ff.info_base) +
                                FA_W'(code_ff - desc_rd_ff.code_begin);
                     purp_in  = ccg_pkg::PURP_TABLE;
                     state_in = FETCH_STATE;
                  end
                  ccg_pkg::METH_SCAN: begin
                     fa_in    = FA_W'(desc_rd_ff.info_base);
                     purp_in  = ccg_pkg::PURP_COUNT;
                     state_in = FETCH_STATE;
                  end
                  default: begin
                     // unused method never maps
                     res_idx_in      = ccg_pkg::NOT_FOUND_INDEX;
                     cached_index_in = ccg_pkg::NOT_FOUND_INDEX;
                     state_in        = ccg_pkg::ST_DONE;
                  end
               endcase
            end else if (slot_cnt_ff == LAST_SLOT) begin
               res_idx_in      = ccg_pkg::NOT_FOUND_INDEX;
               cached_index_in = ccg_pkg::NOT_FOUND_INDEX;
               state_in        = ccg_pkg::ST_DONE;
            end else begin
               slot_cnt_in = slot_cnt_ff + 1'b1;
            end
         end

         ccg_pkg::ST_SEARCH: begin
            if (lo_ff > hi_ff) begin
               res_idx_in      = ccg_pkg::NOT_FOUND_INDEX;
               cached_index_in = ccg_pkg::NOT_FOUND_INDEX;
               state_in        = ccg_pkg::ST_DONE;
            end else begin
               mid_in     = probe_mid;
               fa_in      = FA_W'(base_ff) + FA_W'(1) + {probe_mid, 1'b0};
               purp_in    = ccg_pkg::PURP_KEY;
               red_cnt_in = RED_TOP;
               state_in   = FETCH_STATE;
            end
         end

         ccg_pkg::ST_MOD: begin
            // one restoring-subtract step toward address modulo store depth
            if ({1'b0, fa_ff} >= red_sub) begin
               fa_in = fa_ff - red_sub[FA_W-1:0];
            end
            if (red_cnt_ff == '0) begin
               state_in = ccg_pkg::ST_ACCESS;
            end else begin
               red_cnt_in = red_cnt_ff - 1'b1;
            end
         end

         ccg_pkg::ST_ACCESS: begin
            if (purp_ff == ccg_pkg::PURP_WRITE) begin
               mem_we   = 1'b1;
               state_in = ccg_pkg::ST_DONE;
            end else begin
               state_in = ccg_pkg::ST_DATA;
            end
         end

         ccg_pkg::ST_DATA: begin
            case (purp_ff)
               ccg_pkg::PURP_DIRECT: begin
                  res_idx_in      = word_rd_ff + off_ff;
                  cached_index_in = word_rd_ff + off_ff;
                  state_in        = ccg_pkg::ST_DONE;
               end
               ccg_pkg::PURP_TABLE, ccg_pkg::PURP_VALUE: begin
                  res_idx_in      = word_rd_ff;
                  cached_index_in = word_rd_ff;
                  state_in        = ccg_pkg::ST_DONE;
               end
               ccg_pkg::PURP_COUNT: begin
                  lo_in    = '0;
                  hi_in    = $signed({2'b00, word_rd_ff}) - 18'sd1;
                  state_in = ccg_pkg::ST_SEARCH;
               end
               ccg_pkg::PURP_KEY: begin
                  if (word_rd_ff < code_ff) begin
                     lo_in    = $signed({1'b0, mid_ff}) + 18'sd1;
                     state_in = ccg_pkg::ST_SEARCH;
                  end else if (word_rd_ff > code_ff) begin
                     hi_in    = $signed({1'b0, mid_ff}) - 18'sd1;
                     state_in = ccg_pkg::ST_SEARCH;
                  end else begin
                     // key matches: fetch the index word right after it
                     fa_in      = FA_W'(base_ff) + FA_W'(2) + {mid_ff, 1'b0};
                     purp_in    = ccg_pkg::PURP_VALUE;
                     red_cnt_in = RED_TOP;
                     state_in   = FETCH_STATE;
                  end
               end
               default: begin
                  state_in = ccg_pkg::ST_DONE;
               end
            endcase
         end

         ccg_pkg::ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = res_hit_ff;
               if (!res_lookup_ff) begin
                  rsp_glyph_in = '0;
                  rsp_found_in = 1'b0;
               end else if (res_idx_ff != ccg_pkg::NOT_FOUND_INDEX) begin
                  rsp_glyph_in = res_idx_ff;
                  rsp_found_in = 1'b1;
               end else begin
                  rsp_glyph_in = alt_ff;
                  rsp_found_in = 1'b0;
               end
               state_in = ccg_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = ccg_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ccg_pkg::ST_IDLE;
         rsp_valid_ff    <= 1'b0;
         en_ff           <= '0;
         cached_code_ff  <= '0;
         cached_index_ff <= ccg_pkg::NOT_FOUND_INDEX;
         alt_ff          <= '0;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         en_ff           <= en_in;
         cached_code_ff  <= cached_code_in;
         cached_index_ff <= cached_index_in;
         alt_ff          <= alt_in;
      end
   end

   // working and result payload
   always_ff @(posedge clock) begin
      purp_ff       <= purp_in;
      slot_cnt_ff   <= slot_cnt_in;
      red_cnt_ff    <= red_cnt_in;
      fa_ff         <= fa_in;
      code_ff       <= code_in;
      off_ff        <= off_in;
      base_ff       <= base_in;
      wval_ff       <= wval_in;
      mid_ff        <= mid_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      res_idx_ff    <= res_idx_in;
      res_lookup_ff <= res_lookup_in;
      res_hit_ff    <= res_hit_in;
      rsp_glyph_ff  <= rsp_glyph_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_hit_ff    <= rsp_hit_in;
   end

   // descriptor store: read one slot ahead so the compare sees it next cycle
   always_ff @(posedge clock) begin
      if (desc_we) begin
         desc_mem[desc_waddr] <= desc_wdata;
      end
      desc_rd_ff <= desc_mem[slot_cnt_in];
   end

   // single-port word store, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         word_mem[fa_ff[ADDR_W-1:0]] <= wval_ff;
      end
      word_rd_ff <= word_mem[fa_ff[ADDR_W-1:0]];
   end

endmodule

`default_nettype wire

/* sv/ccg_checker.sv */
// ----------------------------------------------------------------------------
// Glyph index lookup port checker
// Watches the core's ports for handshake and result consistency.
// ----------------------------------------------------------------------------
`default_nettype none

`include "char_code_to_glyph_index_core_defines.svh"

module ccg_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [15:0] rsp_glyph_index,
   input wire logic        rsp_found,
   input wire logic        rsp_cache_hit
);

   // a stalled response stays offered
   `CCG_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid, "response dropped while stalled")

   // a found index is never the not-found marker
   `CCG_ASSERT_NOW(a_found_real, rsp_valid && rsp_found, rsp_glyph_index != ccg_pkg::NOT_FOUND_INDEX, "found with not-found index")

   // one transaction at a time: busy right after an accept
   `CCG_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall, "request taken twice in a row")

   // a stalled response payload holds
   `CCG_ASSERT_NEXT(a_rsp_stable, rsp_valid && rsp_stall, $stable(rsp_glyph_index) && $stable(rsp_found) && $stable(rsp_cache_hit), "response changed while stalled")

endmodule

bind char_code_to_glyph_index_core ccg_checker u_ccg_checker (.*);

`default_nettype wire
